// ===== hw/rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Line substring filter package
// Shared constants, types and the case folding function of the line filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

  // Window and line limits.
  localparam int unsigned PatternBytes = 16;
  localparam int unsigned LineLimit    = 511;
  localparam int unsigned RegPatBytes  = 16;  // bytes held by the two pattern registers
  localparam int unsigned PatIdxW      = $clog2(PatternBytes);
  localparam int unsigned FillW        = $clog2(PatternBytes + 1);
  localparam int unsigned LenW         = $clog2(LineLimit + 1);
  localparam int unsigned PlenW        = 5;
  localparam int unsigned CountW       = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLow    = 3'd0,
    RegPatternHigh   = 3'd1,
    RegPatternLength = 3'd2,
    RegIgnoreCase    = 3'd3,
    RegInvert        = 3'd4,
    RegCountOnly     = 3'd5
  } reg_idx_e;

  typedef enum logic {
    ReqData = 1'b0,
    ReqEnd  = 1'b1
  } req_type_e;

  typedef enum logic {
    ReportLine  = 1'b0,
    ReportCount = 1'b1
  } report_kind_e;

  localparam logic [7:0] NewlineByte = 8'd10;
  localparam logic [7:0] NulByte     = 8'd0;
  localparam logic [7:0] UpperA      = 8'd65;
  localparam logic [7:0] UpperZ      = 8'd90;
  localparam logic [7:0] CaseOffset  = 8'd32;

  // Result queue sizing: an end request can push two results.
  localparam int unsigned MaxResults  = 2;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned PushCntW    = $clog2(MaxResults + 1);

  // Control shared by every cell of the window chain.
  typedef struct packed {
    logic shift;
    logic ignore_case;
  } cell_ctrl_t;

  // One result as it waits in the queue.
  typedef struct packed {
    report_kind_e        kind;
    logic [CountW-1:0]   line_number;
    logic [CountW-1:0]   match_total;
    logic                last;
  } report_t;

  // Folds ASCII upper case to lower case when enabled.
  function automatic logic [7:0] fold_byte(logic [7:0] c, logic ignore_case);
    logic [7:0] r;
    r = c;
    if (ignore_case && (c >= UpperA) && (c <= UpperZ)) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/line_substring_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Line substring filter unit
// Scans a byte stream line by line for a fixed pattern of up to sixteen bytes
// and reports selected lines and a final count.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  --------------------------------
//  in        sink       in_valid_i/in_stall_o  req_type_i, data_byte_i
//  out       source     out_valid_o/out_stall_i report_kind_o, line_number_o,
//                                              match_total_o, last_o
//  cfg       sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
//  One byte request is taken every cycle unless in_stall_o is high; the window
//  compare is done in the same cycle by the row of sixteen cells, so the rate is
//  one request a cycle while not stalled. Results reach the output through the
//  registered result queue, which holds four entries; in_stall_o rises once
//  three are waiting, since an end request can push two results at once.
//  Reset clears the configuration, the line state, both counters and the queue.
//
module line_substring_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input request channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [7:0]                    data_byte_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          report_kind_o,
  output logic [lsf_pkg::CountW-1:0]    line_number_o,
  output logic [lsf_pkg::CountW-1:0]    match_total_o,
  output logic                          last_o,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [lsf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lsf_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [lsf_pkg::CfgDataW-1:0] pat_low_q;
  logic [lsf_pkg::CfgDataW-1:0] pat_high_q;
  logic [lsf_pkg::PlenW-1:0]    pat_len_q;
  logic                         ignore_case_q;
  logic                         invert_q;
  logic                         count_only_q;

  // Line state and counters.
  logic [lsf_pkg::FillW-1:0]    fill_q, fill_d;
  logic                         hit_q, hit_d;
  logic [lsf_pkg::LenW-1:0]     stored_q, stored_d;
  logic                         nul_q, nul_d;
  logic [lsf_pkg::CountW-1:0]   lines_q, lines_d;
  logic [lsf_pkg::CountW-1:0]   selected_q, selected_d;

  // Request decode.
  logic                         in_acc;
  logic                         is_end;
  logic                         is_nl;
  logic                         is_data;
  logic                         room;
  logic                         take;
  logic                         shift;
  logic                         close_line;

  // Window chain.
  logic [(lsf_pkg::RegPatBytes*8)-1:0] pat_all;
  logic [7:0]                   pat_b     [lsf_pkg::PatternBytes];
  logic [7:0]                   aligned   [lsf_pkg::PatternBytes];
  logic [lsf_pkg::PatternBytes-1:0] care;
  logic [lsf_pkg::PatternBytes-1:0] cell_match;
  logic [7:0]                   chain_in  [lsf_pkg::PatternBytes];
  logic [7:0]                   chain_out [lsf_pkg::PatternBytes];
  lsf_pkg::cell_ctrl_t          cell_ctrl;
  logic [lsf_pkg::FillW-1:0]    plen;
  logic [lsf_pkg::FillW-1:0]    fill_inc;
  logic                         hit_now;

  // Line close.
  logic                         line_sel;
  logic [lsf_pkg::CountW-1:0]   lines_inc;
  logic [lsf_pkg::CountW-1:0]   selected_inc;
  logic                         line_report;

  // Result queue.
  logic [lsf_pkg::PushCntW-1:0] push_n;
  lsf_pkg::report_t             wr0, wr1, head;
  logic                         pop;
  logic [lsf_pkg::QueueCntW-1:0] q_count;

  // --------------------------------------------------------------------------
  // Handshakes. Stall whenever the queue cannot take a full end request.
  // --------------------------------------------------------------------------
  assign in_stall_o = (q_count >
                       lsf_pkg::QueueCntW'(lsf_pkg::QueueDepth - lsf_pkg::MaxResults));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  assign is_end  = (lsf_pkg::req_type_e'(req_type_i) == lsf_pkg::ReqEnd);
  assign is_nl   = !is_end && (data_byte_i == lsf_pkg::NewlineByte);
  assign is_data = !is_end && !is_nl;

  // Bytes past the line limit still count as part of the line but are dropped.
  assign room  = (stored_q < lsf_pkg::LenW'(lsf_pkg::LineLimit));
  assign take  = in_acc && is_data && room;
  assign shift = take && !nul_q && (data_byte_i != lsf_pkg::NulByte);
  assign close_line = in_acc && !is_data;

  // --------------------------------------------------------------------------
  // Pattern alignment. Cell k holds the k-th most recent byte, which must
  // match pattern byte plen-1-k when k lies inside the active length.
  // --------------------------------------------------------------------------
  assign plen = (pat_len_q > lsf_pkg::PlenW'(lsf_pkg::PatternBytes)) ?
                lsf_pkg::FillW'(lsf_pkg::PatternBytes) : lsf_pkg::FillW'(pat_len_q);
  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    for (int j = 0; j < lsf_pkg::PatternBytes; j++) begin
      if (j < lsf_pkg::RegPatBytes) begin
        pat_b[j] = pat_all[j*8 +: 8];
      end else begin
        pat_b[j] = '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < lsf_pkg::PatternBytes; k++) begin
      care[k]    = (lsf_pkg::FillW'(k) < plen);
      aligned[k] = pat_b[lsf_pkg::PatIdxW'(plen - lsf_pkg::FillW'(k) - lsf_pkg::FillW'(1))];
    end
  end

  assign cell_ctrl.shift       = shift;
  assign cell_ctrl.ignore_case = ignore_case_q;

  // The newest byte enters cell zero and ages one cell per shift.
  always_comb begin
    chain_in[0] = data_byte_i;
    for (int k = 1; k < lsf_pkg::PatternBytes; k++) begin
      chain_in[k] = chain_out[k-1];
    end
  end

  for (genvar g = 0; g < lsf_pkg::PatternBytes; g++) begin : g_cell
    lsf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .byte_i  (chain_in[g]),
      .pat_i   (aligned[g]),
      .care_i  (care[g]),
      .byte_o  (chain_out[g]),
      .match_o (cell_match[g])
    );
  end

  assign fill_inc = (fill_q < lsf_pkg::FillW'(lsf_pkg::PatternBytes)) ?
                    fill_q + lsf_pkg::FillW'(1) : fill_q;
  // A hit needs a nonempty pattern and a window that already holds it.
  assign hit_now  = shift && (plen != '0) && (fill_inc >= plen) && (&cell_match);

  // --------------------------------------------------------------------------
  // Line close: an empty pattern selects every line, then invert applies.
  // Both counters saturate at all ones.
  // --------------------------------------------------------------------------
  assign line_sel     = ((plen == '0) || hit_q) ^ invert_q;
  assign lines_inc    = (lines_q == '1) ? lines_q : lines_q + lsf_pkg::CountW'(1);
  assign selected_inc = !line_sel ? selected_q :
                        ((selected_q == '1) ? selected_q : selected_q + lsf_pkg::CountW'(1));
  assign line_report  = close_line && line_sel && !count_only_q;

  always_comb begin
    fill_d     = fill_q;
    hit_d      = hit_q;
    stored_d   = stored_q;
    nul_d      = nul_q;
    lines_d    = lines_q;
    selected_d = selected_q;
    if (take) begin
      stored_d = stored_q + lsf_pkg::LenW'(1);
      if (!nul_q && (data_byte_i == lsf_pkg::NulByte)) begin
        nul_d = 1'b1;
      end
    end
    if (shift) begin
      fill_d = fill_inc;
    end
    if (hit_now) begin
      hit_d = 1'b1;
    end
    if (close_line) begin
      fill_d     = '0;
      hit_d      = 1'b0;
      stored_d   = '0;
      nul_d      = 1'b0;
      lines_d    = lines_inc;
      selected_d = selected_inc;
      // End of input starts a fresh stream.
      if (is_end) begin
        lines_d    = '0;
        selected_d = '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly. An end request gives the count after any line report.
  // --------------------------------------------------------------------------
  always_comb begin
    wr0.kind        = lsf_pkg::ReportLine;
    wr0.line_number = lines_inc;
    wr0.match_total = selected_inc;
    wr0.last        = !is_end;
    wr1.kind        = lsf_pkg::ReportCount;
    wr1.line_number = lines_inc;
    wr1.match_total = selected_inc;
    wr1.last        = 1'b1;
    push_n          = '0;
    if (close_line && is_end) begin
      if (line_report) begin
        push_n = lsf_pkg::PushCntW'(2);
      end else begin
        wr0    = wr1;
        push_n = lsf_pkg::PushCntW'(1);
      end
    end else if (line_report) begin
      push_n = lsf_pkg::PushCntW'(1);
    end
  end

  lsf_out_queue u_out_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .wr0_i    (wr0),
    .wr1_i    (wr1),
    .pop_i    (pop),
    .head_o   (head),
    .valid_o  (out_valid_o),
    .count_o  (q_count)
  );

  assign report_kind_o = head.kind;
  assign line_number_o = head.line_number;
  assign match_total_o = head.match_total;
  assign last_o        = head.last;

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q     <= '0;
      pat_high_q    <= '0;
      pat_len_q     <= '0;
      ignore_case_q <= 1'b0;
      invert_q      <= 1'b0;
      count_only_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (lsf_pkg::reg_idx_e'(cfg_idx_i))
        lsf_pkg::RegPatternLow:    pat_low_q     <= cfg_data_i;
        lsf_pkg::RegPatternHigh:   pat_high_q    <= cfg_data_i;
        lsf_pkg::RegPatternLength: pat_len_q     <= cfg_data_i[lsf_pkg::PlenW-1:0];
        lsf_pkg::RegIgnoreCase:    ignore_case_q <= cfg_data_i[0];
        lsf_pkg::RegInvert:        invert_q      <= cfg_data_i[0];
        lsf_pkg::RegCountOnly:     count_only_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      hit_q      <= 1'b0;
      stored_q   <= '0;
      nul_q      <= 1'b0;
      lines_q    <= '0;
      selected_q <= '0;
    end else begin
      fill_q     <= fill_d;
      hit_q      <= hit_d;
      stored_q   <= stored_d;
      nul_q      <= nul_d;
      lines_q    <= lines_d;
      selected_q <= selected_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end) |=> out_valid_o)
    else $error("end request did not produce a count result");

  a_end_clears_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end) |=> ((lines_q == '0) && (selected_q == '0) && (fill_q == '0)))
    else $error("counters not cleared after end of input");

  a_line_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= lsf_pkg::LenW'(lsf_pkg::LineLimit))
    else $error("stored line length past the line limit");

  a_selected_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    selected_q <= lines_q)
    else $error("more selected lines than lines seen");

endmodule

// ===== hw/rtl/lsf_cell.sv =====
// ----------------------------------------------------------------------------
// Line substring filter window cell
// Holds one byte of the recent-byte window and compares the byte it takes in.
// ----------------------------------------------------------------------------
module lsf_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsf_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          pat_i,
  input  logic                care_i,
  output logic [7:0]          byte_o,
  output logic                match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // The compare looks at the incoming byte, which this cell holds after a shift.
  assign byte_d  = ctrl_i.shift ? byte_i : byte_q;
  assign byte_o  = byte_q;
  assign match_o = !care_i ||
                   (lsf_pkg::fold_byte(byte_i, ctrl_i.ignore_case) ==
                    lsf_pkg::fold_byte(pat_i, ctrl_i.ignore_case));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// ===== hw/rtl/lsf_out_queue.sv =====
// ----------------------------------------------------------------------------
// Line substring filter result queue
// Small register queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module lsf_out_queue (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [lsf_pkg::PushCntW-1:0]          push_n_i,
  input  lsf_pkg::report_t                      wr0_i,
  input  lsf_pkg::report_t                      wr1_i,
  input  logic                                  pop_i,
  output lsf_pkg::report_t                      head_o,
  output logic                                  valid_o,
  output logic [lsf_pkg::QueueCntW-1:0]         count_o
);

  lsf_pkg::report_t                     entry_q [lsf_pkg::QueueDepth];
  logic [lsf_pkg::QueuePtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [lsf_pkg::QueuePtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [lsf_pkg::QueueCntW-1:0]        cnt_q, cnt_d;
  logic [lsf_pkg::QueuePtrW-1:0]        wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + lsf_pkg::QueuePtrW'(1);
  assign wr_ptr_d   = wr_ptr_q + lsf_pkg::QueuePtrW'(push_n_i);
  assign rd_ptr_d   = rd_ptr_q + lsf_pkg::QueuePtrW'(pop_i);
  assign cnt_d      = cnt_q + lsf_pkg::QueueCntW'(push_n_i) - lsf_pkg::QueueCntW'(pop_i);

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != '0) begin
      entry_q[wr_ptr_q] <= wr0_i;
    end
    if (push_n_i == lsf_pkg::PushCntW'(lsf_pkg::MaxResults)) begin
      entry_q[wr_ptr_nxt] <= wr1_i;
    end
  end

  // The top level only pushes when the queue has room for a full request.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lsf_pkg::QueueCntW'(lsf_pkg::QueueDepth))
    else $error("result queue overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("result queue popped while empty");

endmodule
